FILE: sv/cht_pkg.sv
`default_nettype none
package cht_pkg;

    localparam int DATA_W        = 32;
    localparam int TC_BITS       = 30;
    localparam int DEF_FRAC_BITS = 16;

    // basis polynomial width, product/sum width, wide accumulator width
    localparam int HW  = 34;
    localparam int SW  = 68;
    localparam int AW  = 104;
    localparam int T2W = SW - TC_BITS;

    // quotient bits kept for the speed division; larger quotients saturate
    localparam int Q2_BITS = 34;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_START_POS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_SPD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_POS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_SPD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 3'd4;

    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_RUN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_END  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ZERO = 2'd2;

    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos;
        logic signed [T2W-1:0]    t2;
        logic                     neg;
        logic                     lnz;
        logic                     ovf;
        logic [MODE_W-1:0]        mode;
    } t_r2_pay;

    function automatic logic signed [DATA_W-1:0] f_sat32(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] vmax;
        logic signed [AW-1:0] vmin;
        vmax = $signed(AW'(32'h7FFF_FFFF));
        vmin = $signed({{(AW-31){1'b1}}, 31'b0});
        if (v > vmax) begin
            return $signed(32'h7FFF_FFFF);
        end else if (v < vmin) begin
            return $signed(32'h8000_0000);
        end
        return v[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: sv/cubic_hermite_trajectory.sv
// Cubic Hermite trajectory generator.
// Configuration channel (i_cfg_*): register index and 32-bit data, always ready.
//   0 start position, 1 start speed, 2 end position, 3 end speed, 4 duration.
//   Write registers only while no sample is in flight.
// Input stream (s_axis_*): tdata = sample time, unsigned Q16.16 by default.
// Output stream (m_axis_*): tdata = {speed, position}, both signed, saturated.
// Samples are independent; one sample is taken per cycle when the pipe moves.
// From input transfer to output valid, a sample passes a 30-cell
// restoring divider row that forms normalized time, nine arithmetic stages
// that evaluate the basis polynomials and products, a 34-cell divider row
// that forms the speed term, and one output register.
// When the receiver stalls with a result held, the whole pipe freezes and
// s_axis_tready drops; it stays high whenever the output register is empty
// or being drained. Reset clears all valid flags and the configuration
// registers to zero (zero duration: both results read zero).
`default_nettype none
module cubic_hermite_trajectory
    import cht_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DATA_W-1:0]    i_cfg_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [31:0]          s_axis_tdata,   // [31:0] sample_time
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [63:0]               m_axis_tdata    // [31:0] position, [63:32] speed
);

    localparam int K_SH  = TC_BITS - FRAC_BITS;
    localparam int P_SH  = TC_BITS + FRAC_BITS;
    localparam int PHW   = SW - 32 + 33;
    localparam int TW    = Q2_BITS + 2;
    localparam int R2_PW = $bits(t_r2_pay);
    localparam logic signed [HW-1:0] ONE_Q = HW'(1) << TC_BITS;
    localparam logic signed [TW-1:0] T1_LIM = TW'(1) << Q2_BITS;

    // configuration
    logic signed [DATA_W-1:0] r_p0, r_v0, r_p1, r_v1;
    logic [DATA_W-1:0]        r_dur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0  <= '0;
            r_v0  <= '0;
            r_p1  <= '0;
            r_v1  <= '0;
            r_dur <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_START_POS: r_p0  <= i_cfg_data;
                REG_START_SPD: r_v0  <= i_cfg_data;
                REG_END_POS:   r_p1  <= i_cfg_data;
                REG_END_SPD:   r_v1  <= i_cfg_data;
                REG_DURATION:  r_dur <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // global pipe enable
    logic r_out_vld;
    logic w_en;
    assign w_en          = ~r_out_vld | m_axis_tready;
    assign s_axis_tready = w_en;

    // input classification and normalized-time division
    logic [MODE_W-1:0] w_mode;
    logic [DATA_W-1:0] w_t;
    t_pipe_ctl         w_ctl1;

    assign w_t    = s_axis_tdata;
    assign w_mode = (r_dur == '0) ? MODE_ZERO : ((w_t >= r_dur) ? MODE_END : MODE_RUN);
    assign w_ctl1.en  = w_en;
    assign w_ctl1.vld = s_axis_tvalid;

    logic               w1_vld;
    logic [TC_BITS-1:0] w1_tc;
    logic [DATA_W-1:0]  w1_rem;
    logic [MODE_W-1:0]  w1_mode;

    cht_div_row #(
        .STEPS (TC_BITS),
        .NW    (1),
        .PW    (MODE_W)
    ) u_row_tc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl1),
        .i_div   (r_dur),
        .i_rem   ((w_mode == MODE_RUN) ? w_t : '0),
        .i_num   (1'b0),
        .i_pay   (w_mode),
        .o_vld   (w1_vld),
        .o_quo   (w1_tc),
        .o_rem   (w1_rem),
        .o_pay   (w1_mode)
    );

    // P1: tc^2
    logic                   r_p1_vld;
    logic [TC_BITS-1:0]     r_p1_tc, r_p1_tc2;
    logic [MODE_W-1:0]      r_p1_mode;
    logic [2*TC_BITS-1:0]   w_sq;
    assign w_sq = (2*TC_BITS)'(w1_tc) * (2*TC_BITS)'(w1_tc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p1_vld <= 1'b0;
        else if (w_en) r_p1_vld <= w1_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_tc   <= w1_tc;
            r_p1_tc2  <= w_sq[2*TC_BITS-1:TC_BITS];
            r_p1_mode <= w1_mode;
        end
    end

    // P2: tc^3
    logic                 r_p2_vld;
    logic [TC_BITS-1:0]   r_p2_tc, r_p2_tc2, r_p2_tc3;
    logic [MODE_W-1:0]    r_p2_mode;
    logic [2*TC_BITS-1:0] w_cu;
    assign w_cu = (2*TC_BITS)'(r_p1_tc2) * (2*TC_BITS)'(r_p1_tc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p2_vld <= 1'b0;
        else if (w_en) r_p2_vld <= r_p1_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_tc   <= r_p1_tc;
            r_p2_tc2  <= r_p1_tc2;
            r_p2_tc3  <= w_cu[2*TC_BITS-1:TC_BITS];
            r_p2_mode <= r_p1_mode;
        end
    end

    // P3: basis polynomials and their derivatives
    logic                 r_p3_vld;
    logic [MODE_W-1:0]    r_p3_mode;
    logic signed [HW-1:0] r_h00, r_h10, r_h01, r_h11, r_g, r_k0, r_k1;
    logic signed [HW-1:0] w_e1, w_e2, w_e3;
    assign w_e1 = $signed(HW'(r_p2_tc));
    assign w_e2 = $signed(HW'(r_p2_tc2));
    assign w_e3 = $signed(HW'(r_p2_tc3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p3_vld <= 1'b0;
        else if (w_en) r_p3_vld <= r_p2_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h00 <= (w_e3 <<< 1) - w_e2 - (w_e2 <<< 1) + ONE_Q;
            r_h10 <= w_e3 - (w_e2 <<< 1) + w_e1;
            r_h01 <= (w_e2 <<< 1) + w_e2 - (w_e3 <<< 1);
            r_h11 <= w_e3 - w_e2;
            r_g   <= (w_e2 <<< 2) + (w_e2 <<< 1) - (w_e1 <<< 2) - (w_e1 <<< 1);
            r_k0  <= (w_e2 <<< 1) + w_e2 - (w_e1 <<< 2) + ONE_Q;
            r_k1  <= (w_e2 <<< 1) + w_e2 - (w_e1 <<< 1);
            r_p3_mode <= r_p2_mode;
        end
    end

    // P4: products with the end points
    logic                 r_p4_vld;
    logic [MODE_W-1:0]    r_p4_mode;
    logic signed [SW-1:0] r_m00, r_m01, r_m10, r_m11, r_mg, r_mk0, r_mk1;
    logic signed [DATA_W:0] w_dp;
    assign w_dp = (DATA_W+1)'(r_p0) - (DATA_W+1)'(r_p1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p4_vld <= 1'b0;
        else if (w_en) r_p4_vld <= r_p3_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m00 <= SW'(r_h00) * SW'(r_p0);
            r_m01 <= SW'(r_h01) * SW'(r_p1);
            r_m10 <= SW'(r_h10) * SW'(r_v0);
            r_m11 <= SW'(r_h11) * SW'(r_v1);
            r_mg  <= SW'(r_g) * SW'(w_dp);
            r_mk0 <= SW'(r_k0) * SW'(r_v0);
            r_mk1 <= SW'(r_k1) * SW'(r_v1);
            r_p4_mode <= r_p3_mode;
        end
    end

    // P5: sums, magnitude of the speed numerator
    logic                 r_p5_vld;
    logic [MODE_W-1:0]    r_p5_mode;
    logic signed [SW-1:0] r_s1, r_s2, r_kv;
    logic [SW-1:0]        r_p5_n;
    logic                 r_p5_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p5_vld <= 1'b0;
        else if (w_en) r_p5_vld <= r_p4_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1      <= r_m00 + r_m01;
            r_s2      <= r_m10 + r_m11;
            r_kv      <= r_mk0 + r_mk1;
            r_p5_n    <= r_mg[SW-1] ? SW'(-r_mg) : SW'(r_mg);
            r_p5_neg  <= r_mg[SW-1];
            r_p5_mode <= r_p4_mode;
        end
    end

    // P6: speed sum times duration, split in two partial products
    logic                  r_p6_vld;
    logic [MODE_W-1:0]     r_p6_mode;
    logic signed [PHW-1:0] r_ph;
    logic [63:0]           r_pl;
    logic signed [SW-1:0]  r_p6_s1, r_p6_kv;
    logic [SW-1:0]         r_p6_n;
    logic                  r_p6_neg;
    logic signed [SW-33:0] w_shi;
    logic signed [DATA_W:0] w_d33;
    assign w_shi = $signed(r_s2[SW-1:32]);
    assign w_d33 = $signed({1'b0, r_dur});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p6_vld <= 1'b0;
        else if (w_en) r_p6_vld <= r_p5_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ph      <= PHW'(w_shi) * PHW'(w_d33);
            r_pl      <= 64'(r_s2[31:0]) * 64'(r_dur);
            r_p6_s1   <= r_s1;
            r_p6_kv   <= r_kv;
            r_p6_n    <= r_p5_n;
            r_p6_neg  <= r_p5_neg;
            r_p6_mode <= r_p5_mode;
        end
    end

    // P7: join partial products
    logic                 r_p7_vld;
    logic [MODE_W-1:0]    r_p7_mode;
    logic signed [AW-1:0] r_pp;
    logic signed [SW-1:0] r_p7_s1, r_p7_kv;
    logic [SW-1:0]        r_p7_n;
    logic                 r_p7_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p7_vld <= 1'b0;
        else if (w_en) r_p7_vld <= r_p6_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pp      <= (AW'(r_ph) <<< 32) + $signed(AW'(r_pl));
            r_p7_s1   <= r_p6_s1;
            r_p7_kv   <= r_p6_kv;
            r_p7_n    <= r_p6_n;
            r_p7_neg  <= r_p6_neg;
            r_p7_mode <= r_p6_mode;
        end
    end

    // P8: position accumulator
    logic                 r_p8_vld;
    logic [MODE_W-1:0]    r_p8_mode;
    logic signed [AW-1:0] r_acc;
    logic signed [SW-1:0] r_p8_kv;
    logic [SW-1:0]        r_p8_n;
    logic                 r_p8_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p8_vld <= 1'b0;
        else if (w_en) r_p8_vld <= r_p7_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_acc     <= r_pp + (AW'(r_p7_s1) <<< FRAC_BITS);
            r_p8_kv   <= r_p7_kv;
            r_p8_n    <= r_p7_n;
            r_p8_neg  <= r_p7_neg;
            r_p8_mode <= r_p7_mode;
        end
    end

    // P9: position scale and clamp, set up the speed division
    logic                 r_p9_vld;
    t_r2_pay              r_p9_pay;
    logic [DATA_W-1:0]    r_p9_rem;
    logic [Q2_BITS-1:0]   r_p9_bits;
    logic [63:0]          w_top;
    logic                 w_ovf;
    logic signed [AW-1:0] w_psh;

    // numerator / (D * 2^K) == floor(numerator / 2^K) / D
    assign w_top = 64'(r_p8_n >> (K_SH + Q2_BITS));
    assign w_ovf = w_top >= 64'(r_dur);
    assign w_psh = r_acc >>> P_SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p9_vld <= 1'b0;
        else if (w_en) r_p9_vld <= r_p8_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p9_pay.pos  <= f_sat32(w_psh);
            r_p9_pay.t2   <= T2W'(r_p8_kv >>> TC_BITS);
            r_p9_pay.neg  <= r_p8_neg;
            r_p9_pay.lnz  <= |r_p8_n[K_SH-1:0];
            r_p9_pay.ovf  <= w_ovf;
            r_p9_pay.mode <= r_p8_mode;
            r_p9_rem      <= w_ovf ? '0 : w_top[DATA_W-1:0];
            r_p9_bits     <= r_p8_n[K_SH+Q2_BITS-1:K_SH];
        end
    end

    // speed division row
    t_pipe_ctl          w_ctl2;
    logic               w2_vld;
    logic [Q2_BITS-1:0] w2_quo;
    logic [DATA_W-1:0]  w2_rem;
    logic [R2_PW-1:0]   w2_pay_v;
    t_r2_pay            w2_pay;

    assign w_ctl2.en  = w_en;
    assign w_ctl2.vld = r_p9_vld;
    assign w2_pay     = w2_pay_v;

    cht_div_row #(
        .STEPS (Q2_BITS),
        .NW    (Q2_BITS),
        .PW    (R2_PW)
    ) u_row_spd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl2),
        .i_div   (r_dur),
        .i_rem   (r_p9_rem),
        .i_num   (r_p9_bits),
        .i_pay   (r_p9_pay),
        .o_vld   (w2_vld),
        .o_quo   (w2_quo),
        .o_rem   (w2_rem),
        .o_pay   (w2_pay_v)
    );

    // final: floor for negative quotients, add terms, clamp, special cases
    logic                     w_rnz;
    logic signed [TW-1:0]     w_t1;
    logic signed [AW-1:0]     w_sum;
    logic signed [DATA_W-1:0] w_pos, w_spd;
    logic signed [DATA_W-1:0] r_out_pos, r_out_spd;

    assign w_rnz = w2_pay.lnz | (w2_rem != '0);

    always_comb begin
        if (w2_pay.ovf) begin
            w_t1 = w2_pay.neg ? -T1_LIM : T1_LIM;
        end else if (w2_pay.neg) begin
            w_t1 = -$signed(TW'(w2_quo) + TW'(w_rnz));
        end else begin
            w_t1 = $signed(TW'(w2_quo));
        end
    end

    assign w_sum = AW'(w_t1) + AW'(w2_pay.t2);

    always_comb begin
        unique case (w2_pay.mode)
            MODE_RUN: begin
                w_pos = w2_pay.pos;
                w_spd = f_sat32(w_sum);
            end
            MODE_END: begin
                w_pos = r_p1;
                w_spd = '0;
            end
            default: begin
                w_pos = '0;
                w_spd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else if (w_en) r_out_vld <= w2_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_pos <= w_pos;
            r_out_spd <= w_spd;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_spd, r_out_pos};

    // tc < 1 implies tc^3 <= tc^2 <= tc
    a_tc2_le_tc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_vld |-> (r_p1_tc2 <= r_p1_tc))
        else $error("tc2 exceeds tc");

    a_tc3_le_tc2 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_vld |-> (r_p2_tc3 <= r_p2_tc2))
        else $error("tc3 exceeds tc2");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && r_p9_vld) |=> ($stable(r_p9_pay) && r_p9_vld))
        else $error("pipe moved while stalled");

endmodule
`default_nettype wire

FILE: sv/cht_div_cell.sv
`default_nettype none
module cht_div_cell
    import cht_pkg::*;
#(
    parameter int NW = 1,
    parameter int QW = 2,
    parameter int PW = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_pipe_ctl         i_ctl,
    input  wire logic [DATA_W-1:0] i_div,
    input  wire logic [DATA_W-1:0] i_rem,
    input  wire logic [NW-1:0]     i_num,
    input  wire logic [QW-1:0]     i_quo,
    input  wire logic [PW-1:0]     i_pay,
    output logic                   o_vld,
    output logic [DATA_W-1:0]      o_rem,
    output logic [NW-1:0]          o_num,
    output logic [QW-1:0]          o_quo,
    output logic [PW-1:0]          o_pay
);

    logic              r_vld;
    logic [DATA_W-1:0] r_rem;
    logic [NW-1:0]     r_num;
    logic [QW-1:0]     r_quo;
    logic [PW-1:0]     r_pay;

    logic [DATA_W:0]   w_trial;
    logic [DATA_W+1:0] w_diff;
    logic              w_take;
    logic [DATA_W-1:0] n_rem;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    assign w_trial = {i_rem, i_num[NW-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, i_div};
    assign w_take  = ~w_diff[DATA_W+1];
    assign n_rem   = w_take ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rem <= n_rem;
            r_num <= i_num << 1;
            r_quo <= {i_quo[QW-2:0], w_take};
            r_pay <= i_pay;
        end
    end

    assign o_vld = r_vld;
    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_quo = r_quo;
    assign o_pay = r_pay;

endmodule
`default_nettype wire

FILE: sv/cht_div_row.sv
`default_nettype none
module cht_div_row
    import cht_pkg::*;
#(
    parameter int STEPS = 30,
    parameter int NW    = 1,
    parameter int PW    = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_pipe_ctl         i_ctl,
    input  wire logic [DATA_W-1:0] i_div,
    input  wire logic [DATA_W-1:0] i_rem,
    input  wire logic [NW-1:0]     i_num,
    input  wire logic [PW-1:0]     i_pay,
    output logic                   o_vld,
    output logic [STEPS-1:0]       o_quo,
    output logic [DATA_W-1:0]      o_rem,
    output logic [PW-1:0]          o_pay
);

    logic              w_vld [0:STEPS];
    logic [DATA_W-1:0] w_rem [0:STEPS];
    logic [NW-1:0]     w_num [0:STEPS];
    logic [STEPS-1:0]  w_quo [0:STEPS];
    logic [PW-1:0]     w_pay [0:STEPS];

    assign w_vld[0] = i_ctl.vld;
    assign w_rem[0] = i_rem;
    assign w_num[0] = i_num;
    assign w_quo[0] = '0;
    assign w_pay[0] = i_pay;

    // one quotient bit per cell, MSB first
    for (genvar gi = 0; gi < STEPS; gi++) begin : g_cell
        t_pipe_ctl w_ctl;
        assign w_ctl.en  = i_ctl.en;
        assign w_ctl.vld = w_vld[gi];

        cht_div_cell #(
            .NW (NW),
            .QW (STEPS),
            .PW (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_div   (i_div),
            .i_rem   (w_rem[gi]),
            .i_num   (w_num[gi]),
            .i_quo   (w_quo[gi]),
            .i_pay   (w_pay[gi]),
            .o_vld   (w_vld[gi+1]),
            .o_rem   (w_rem[gi+1]),
            .o_num   (w_num[gi+1]),
            .o_quo   (w_quo[gi+1]),
            .o_pay   (w_pay[gi+1])
        );
    end

    assign o_vld = w_vld[STEPS];
    assign o_quo = w_quo[STEPS];
    assign o_rem = w_rem[STEPS];
    assign o_pay = w_pay[STEPS];

endmodule
`default_nettype wire
